/* rtl/core/gdconv_pkg.sv */
// package: calendar constants, tables and stream layout for the date converter
package gdconv_pkg;

	localparam int S_DATA_W = 72;
	localparam int S_USER_W = 2;
	localparam int M_DATA_W = 56;
	localparam int M_USER_W = 1;

	localparam int JDN_BASE  = 1721425;
	localparam int JDN_MIN   = 1721426;
	localparam int JDN_MAX   = 5373484;
	localparam int DAYS_400Y = 146097;
	localparam int DAYS_100Y = 36524;
	localparam int DAYS_4Y   = 1461;
	localparam int DAYS_1Y   = 365;
	localparam int YEAR_MAX  = 9999;

	// exact floor(x / 100) for x below 43690 as (x * RECIP100) >> RECIP100_SH
	localparam int RECIP100    = 5243;
	localparam int RECIP100_SH = 19;

	// reciprocal estimates, low by at most one
	localparam int R_W     = 22;
	localparam int R100_W  = 16;
	localparam int M400    = (1 << R_W) / DAYS_400Y;
	localparam int M4      = (1 << R100_W) / DAYS_4Y;

	typedef enum logic [1:0] {
		MODE_DATE_TO_JDN = 2'd0,
		MODE_JDN_TO_DATE = 2'd1,
		MODE_ADD_DAYS    = 2'd2
	} mode_t;

	function automatic logic [4:0] month_len(input logic [3:0] m);
		logic [4:0] len;
		unique case (m)
			4'd1, 4'd3, 4'd5, 4'd7, 4'd8, 4'd10, 4'd12: len = 5'd31;
			4'd4, 4'd6, 4'd9, 4'd11:                   len = 5'd30;
			4'd2:                                      len = 5'd28;
			default:                                   len = 5'd0;
		endcase
		return len;
	endfunction

	function automatic logic [8:0] days_before(input logic lp, input logic [3:0] m);
		logic [8:0] db;
		unique case (m)
			4'd3:    db = 9'd59;
			4'd4:    db = 9'd90;
			4'd5:    db = 9'd120;
			4'd6:    db = 9'd151;
			4'd7:    db = 9'd181;
			4'd8:    db = 9'd212;
			4'd9:    db = 9'd243;
			4'd10:   db = 9'd273;
			4'd11:   db = 9'd304;
			4'd12:   db = 9'd334;
			4'd2:    db = 9'd31;
			default: db = 9'd0;
		endcase
		if (lp && m >= 4'd3 && m <= 4'd12) begin
			db = db + 9'd1;
		end
		return db;
	endfunction

endpackage

/* rtl/core/gregorian_date_day_number_converter_core.sv */
// top level: pipelined gregorian date and julian day number converter
//
// one stream in, one stream out. an input word carries the mode in s_axis_tuser
// and the date, day number and day offset in s_axis_tdata. mode 0 checks a date
// and gives its day number, mode 1 turns a day number into a date, mode 2 adds a
// signed offset to a date. every output word gives date, day number, day of year
// and leap flag; m_axis_tuser is the result valid flag, and with it low all data
// fields are zero.
// a new word can be taken every cycle while m_axis_tready does not stall the
// output. there are eleven register stages: date check, day number sum, offset
// add, range check, then two stages for each reciprocal division (400 and 4
// year cycles), century and year picks, and the month pick.
// each stage has its own valid bit and takes a word when it is empty or its
// successor moves, so a stall on m_axis_tready fills bubbles before it reaches
// s_axis_tready; nothing is dropped or repeated.
// reset clears all valid bits and the block is ready on the first cycle after.
module gregorian_date_day_number_converter_core (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            s_axis_tvalid,
	output logic                            s_axis_tready,
	// year_in[13:0], month_in[17:14], day_in[22:18], day_number_in[45:23],
	// day_offset[68:46], zero fill
	input  logic [gdconv_pkg::S_DATA_W-1:0] s_axis_tdata,
	// mode[1:0]
	input  logic [gdconv_pkg::S_USER_W-1:0] s_axis_tuser,
	output logic                            m_axis_tvalid,
	input  logic                            m_axis_tready,
	// year_out[13:0], month_out[17:14], day_out[22:18], day_number_out[45:23],
	// day_of_year[54:46], leap_year[55]
	output logic [gdconv_pkg::M_DATA_W-1:0] m_axis_tdata,
	// valid_res[0]
	output logic [gdconv_pkg::M_USER_W-1:0] m_axis_tuser
);
	import gdconv_pkg::*;

	// stage handshake
	logic vld_s1, vld_s2, vld_s3, vld_s4, vld_s5, vld_s6;
	logic vld_s7, vld_s8, vld_s9, vld_s10, vld_s11;
	logic rdy_s1, rdy_s2, rdy_s3, rdy_s4, rdy_s5, rdy_s6;
	logic rdy_s7, rdy_s8, rdy_s9, rdy_s10, rdy_s11;

	assign rdy_s11 = !vld_s11 || m_axis_tready;
	assign rdy_s10 = !vld_s10 || rdy_s11;
	assign rdy_s9  = !vld_s9  || rdy_s10;
	assign rdy_s8  = !vld_s8  || rdy_s9;
	assign rdy_s7  = !vld_s7  || rdy_s8;
	assign rdy_s6  = !vld_s6  || rdy_s7;
	assign rdy_s5  = !vld_s5  || rdy_s6;
	assign rdy_s4  = !vld_s4  || rdy_s5;
	assign rdy_s3  = !vld_s3  || rdy_s4;
	assign rdy_s2  = !vld_s2  || rdy_s3;
	assign rdy_s1  = !vld_s1  || rdy_s2;
	assign s_axis_tready = rdy_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1  <= 1'b0;
			vld_s2  <= 1'b0;
			vld_s3  <= 1'b0;
			vld_s4  <= 1'b0;
			vld_s5  <= 1'b0;
			vld_s6  <= 1'b0;
			vld_s7  <= 1'b0;
			vld_s8  <= 1'b0;
			vld_s9  <= 1'b0;
			vld_s10 <= 1'b0;
			vld_s11 <= 1'b0;
		end else begin
			if (rdy_s1)  vld_s1  <= s_axis_tvalid;
			if (rdy_s2)  vld_s2  <= vld_s1;
			if (rdy_s3)  vld_s3  <= vld_s2;
			if (rdy_s4)  vld_s4  <= vld_s3;
			if (rdy_s5)  vld_s5  <= vld_s4;
			if (rdy_s6)  vld_s6  <= vld_s5;
			if (rdy_s7)  vld_s7  <= vld_s6;
			if (rdy_s8)  vld_s8  <= vld_s7;
			if (rdy_s9)  vld_s9  <= vld_s8;
			if (rdy_s10) vld_s10 <= vld_s9;
			if (rdy_s11) vld_s11 <= vld_s10;
		end
	end

	// stage 1: unpack, date check, year quotients
	logic [1:0]  mode_in;
	logic [13:0] year_in, p_in;
	logic [3:0]  month_in;
	logic [4:0]  day_in;
	logic [22:0] dn_in, off_in;
	logic [26:0] prod_y, prod_p;
	logic [7:0]  q100_y, q100_p;
	logic        leap_in, date_ok, ok_in;
	logic [5:0]  mlen_in;

	assign mode_in  = s_axis_tuser;
	assign year_in  = s_axis_tdata[13:0];
	assign month_in = s_axis_tdata[17:14];
	assign day_in   = s_axis_tdata[22:18];
	assign dn_in    = s_axis_tdata[45:23];
	assign off_in   = s_axis_tdata[68:46];
	assign p_in     = year_in - 14'd1;
	assign prod_y   = 27'(year_in) * 27'(RECIP100);
	assign prod_p   = 27'(p_in) * 27'(RECIP100);
	assign q100_y   = prod_y[26:RECIP100_SH];
	assign q100_p   = prod_p[26:RECIP100_SH];
	// a century or 400 year boundary lies between y-1 and y exactly when y is a multiple
	assign leap_in  = (year_in[1:0] == 2'b00 && q100_y == q100_p) ||
	                  (q100_y[7:2] != q100_p[7:2]);
	assign mlen_in  = 6'(month_len(month_in)) +
	                  6'(month_in == 4'd2 && leap_in);
	assign date_ok  = year_in != 14'd0 && year_in <= 14'(YEAR_MAX) &&
	                  month_in >= 4'd1 && month_in <= 4'd12 &&
	                  day_in != 5'd0 && 6'(day_in) <= mlen_in;
	assign ok_in    = ((mode_in == MODE_DATE_TO_JDN || mode_in == MODE_ADD_DAYS) && date_ok) ||
	                  mode_in == MODE_JDN_TO_DATE;

	logic        ok_s1;
	logic [1:0]  mode_s1;
	logic [13:0] p_s1;
	logic [7:0]  q100p_s1;
	logic [8:0]  dbd_s1;
	logic [22:0] dn_s1, off_s1;

	always_ff @(posedge clk) begin
		if (rdy_s1) begin
			ok_s1    <= ok_in;
			mode_s1  <= mode_in;
			p_s1     <= p_in;
			q100p_s1 <= q100_p;
			dbd_s1   <= days_before(leap_in, month_in) + 9'(day_in);
			dn_s1    <= dn_in;
			off_s1   <= off_in;
		end
	end

	// stage 2: days before the year
	logic        ok_s2;
	logic [1:0]  mode_s2;
	logic [21:0] base_s2;
	logic [8:0]  dbd_s2;
	logic [22:0] dn_s2, off_s2;

	always_ff @(posedge clk) begin
		if (rdy_s2) begin
			ok_s2   <= ok_s1;
			mode_s2 <= mode_s1;
			base_s2 <= 22'(p_s1) * 22'(DAYS_1Y) + 22'(p_s1[13:2]) +
			           22'(q100p_s1[7:2]) - 22'(q100p_s1);
			dbd_s2  <= dbd_s1;
			dn_s2   <= dn_s1;
			off_s2  <= off_s1;
		end
	end

	// stage 3: day number by mode
	logic        ok_s3;
	logic [24:0] jdn_s3;
	logic [24:0] jdn_date, off_ext;

	assign off_ext  = (mode_s2 == MODE_ADD_DAYS) ? {{2{off_s2[22]}}, off_s2} : 25'd0;
	assign jdn_date = 25'(base_s2) + 25'(dbd_s2) + 25'(JDN_BASE) + off_ext;

	always_ff @(posedge clk) begin
		if (rdy_s3) begin
			ok_s3  <= ok_s2;
			jdn_s3 <= (mode_s2 == MODE_JDN_TO_DATE) ? 25'(dn_s2) : jdn_date;
		end
	end

	// stage 4: range check, day count from 0001-01-01
	logic        ok_s4;
	logic [21:0] r_s4;
	logic [22:0] jdn_s4;
	logic        in_rng;

	assign in_rng = $signed(jdn_s3) >= $signed(25'(JDN_MIN)) &&
	                $signed(jdn_s3) <= $signed(25'(JDN_MAX));

	always_ff @(posedge clk) begin
		if (rdy_s4) begin
			ok_s4  <= ok_s3 && in_rng;
			r_s4   <= 22'(jdn_s3 - 25'(JDN_MIN));
			jdn_s4 <= jdn_s3[22:0];
		end
	end

	// stage 5: 400 year estimate
	logic        ok_s5;
	logic [21:0] r_s5;
	logic [22:0] jdn_s5;
	logic [4:0]  n400e_s5;
	logic [26:0] prod5;

	assign prod5 = 27'(r_s4) * 27'(M400);

	always_ff @(posedge clk) begin
		if (rdy_s5) begin
			ok_s5    <= ok_s4;
			r_s5     <= r_s4;
			jdn_s5   <= jdn_s4;
			n400e_s5 <= prod5[26:R_W];
		end
	end

	// stage 6: 400 year remainder and correction
	logic        ok_s6;
	logic [22:0] jdn_s6;
	logic [4:0]  n400_s6;
	logic [17:0] r400_s6;
	logic [21:0] sub6;
	logic        fix6;

	assign sub6 = r_s5 - 22'(n400e_s5) * 22'(DAYS_400Y);
	assign fix6 = sub6[18:0] >= 19'(DAYS_400Y);

	always_ff @(posedge clk) begin
		if (rdy_s6) begin
			ok_s6   <= ok_s5;
			jdn_s6  <= jdn_s5;
			n400_s6 <= n400e_s5 + 5'(fix6);
			r400_s6 <= fix6 ? 18'(sub6[18:0] - 19'(DAYS_400Y)) : sub6[17:0];
		end
	end

	// stage 7: century, clamped to 3
	logic        ok_s7;
	logic [22:0] jdn_s7;
	logic [4:0]  n400_s7;
	logic [1:0]  n100_s7, n100_c;
	logic [15:0] r100_s7;

	assign n100_c = 2'(r400_s6 >= 18'(DAYS_100Y)) +
	                2'(r400_s6 >= 18'(2 * DAYS_100Y)) +
	                2'(r400_s6 >= 18'(3 * DAYS_100Y));

	always_ff @(posedge clk) begin
		if (rdy_s7) begin
			ok_s7   <= ok_s6;
			jdn_s7  <= jdn_s6;
			n400_s7 <= n400_s6;
			n100_s7 <= n100_c;
			r100_s7 <= 16'(r400_s6 - 18'(n100_c) * 18'(DAYS_100Y));
		end
	end

	// stage 8: 4 year estimate
	logic        ok_s8;
	logic [22:0] jdn_s8;
	logic [4:0]  n400_s8, n4e_s8;
	logic [1:0]  n100_s8;
	logic [15:0] r100_s8;
	logic [21:0] prod8;

	assign prod8 = 22'(r100_s7) * 22'(M4);

	always_ff @(posedge clk) begin
		if (rdy_s8) begin
			ok_s8   <= ok_s7;
			jdn_s8  <= jdn_s7;
			n400_s8 <= n400_s7;
			n100_s8 <= n100_s7;
			r100_s8 <= r100_s7;
			n4e_s8  <= 5'(prod8 >> R100_W);
		end
	end

	// stage 9: 4 year remainder and correction
	logic        ok_s9;
	logic [22:0] jdn_s9;
	logic [4:0]  n400_s9, n4_s9;
	logic [1:0]  n100_s9;
	logic [10:0] r4_s9;
	logic [15:0] sub9;
	logic        fix9;

	assign sub9 = r100_s8 - 16'(n4e_s8) * 16'(DAYS_4Y);
	assign fix9 = sub9[11:0] >= 12'(DAYS_4Y);

	always_ff @(posedge clk) begin
		if (rdy_s9) begin
			ok_s9   <= ok_s8;
			jdn_s9  <= jdn_s8;
			n400_s9 <= n400_s8;
			n100_s9 <= n100_s8;
			n4_s9   <= n4e_s8 + 5'(fix9);
			r4_s9   <= fix9 ? 11'(sub9[11:0] - 12'(DAYS_4Y)) : sub9[10:0];
		end
	end

	// stage 10: year, day of year, leap flag
	logic        ok_s10, leap_s10;
	logic [22:0] jdn_s10;
	logic [13:0] year_s10;
	logic [8:0]  doy_s10;
	logic [1:0]  n1_c;

	assign n1_c = 2'(r4_s9 >= 11'(DAYS_1Y)) +
	              2'(r4_s9 >= 11'(2 * DAYS_1Y)) +
	              2'(r4_s9 >= 11'(3 * DAYS_1Y));

	always_ff @(posedge clk) begin
		if (rdy_s10) begin
			ok_s10   <= ok_s9;
			jdn_s10  <= jdn_s9;
			year_s10 <= 14'(14'(n400_s9) * 14'd400 + 14'(n100_s9) * 14'd100 +
			                14'(n4_s9) * 14'd4 + 14'(n1_c) + 14'd1);
			doy_s10  <= 9'(r4_s9 - 11'(n1_c) * 11'(DAYS_1Y)) + 9'd1;
			leap_s10 <= n1_c == 2'd3 && (n4_s9 != 5'd24 || n100_s9 == 2'd3);
		end
	end

	// stage 11: month pick, output register
	logic        ok_s11, leap_s11;
	logic [22:0] jdn_s11;
	logic [13:0] year_s11;
	logic [3:0]  mon_s11, mon_c;
	logic [4:0]  day_s11;
	logic [8:0]  doy_s11;
	logic [12:2] past_m;

	always_comb begin
		for (int k = 2; k <= 12; k++) begin
			past_m[k] = days_before(leap_s10, 4'(k)) < doy_s10;
		end
		mon_c = 4'd1 + 4'($countones(past_m));
	end

	always_ff @(posedge clk) begin
		if (rdy_s11) begin
			ok_s11   <= ok_s10;
			jdn_s11  <= ok_s10 ? jdn_s10 : 23'd0;
			year_s11 <= ok_s10 ? year_s10 : 14'd0;
			mon_s11  <= ok_s10 ? mon_c : 4'd0;
			day_s11  <= ok_s10 ? 5'(doy_s10 - days_before(leap_s10, mon_c)) : 5'd0;
			doy_s11  <= ok_s10 ? doy_s10 : 9'd0;
			leap_s11 <= ok_s10 && leap_s10;
		end
	end

	assign m_axis_tvalid = vld_s11;
	assign m_axis_tuser  = ok_s11;
	assign m_axis_tdata  = {leap_s11, doy_s11, jdn_s11, day_s11, mon_s11, year_s11};

`ifndef SYNTHESIS
	a_res_fields: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && m_axis_tuser[0] |->
			m_axis_tdata[17:14] != 4'd0 && m_axis_tdata[17:14] <= 4'd12 &&
			m_axis_tdata[22:18] != 5'd0 && m_axis_tdata[54:46] != 9'd0)
		else $error("valid result with empty date fields");

	a_res_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tuser[0] |-> m_axis_tdata == '0)
		else $error("invalid result with nonzero fields");

	a_range: assert property (@(posedge clk) disable iff (!arst_n)
		vld_s4 && ok_s4 |-> r_s4 <= 22'(JDN_MAX - JDN_MIN))
		else $error("day count out of range after check");

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		vld_s5 && !rdy_s6 |=> vld_s5 && $stable(r_s5) && $stable(n400e_s5))
		else $error("stalled stage 5 word changed");

	a_leap: assert property (@(posedge clk) disable iff (!arst_n)
		vld_s10 && ok_s10 && leap_s10 |-> year_s10[1:0] == 2'b00)
		else $error("leap flag on year not divisible by four");
`endif

endmodule
